FILE: hdl/pps_pkg.sv
package pps_pkg;

  // Ready table geometry
  localparam int unsigned SLOTS  = 8;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // Request codes
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_ARRIVE = 1'b1;

  // Input word
  typedef struct packed {
    logic        req_type;
    logic [7:0]  job_id;
    logic [15:0] job_burst;
    logic [7:0]  job_priority;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [7:0]  running_id;
    logic        idle;
    logic        dispatched;
    logic        table_full;
    logic [31:0] now_time;
  } out_word_t;

  // One ready-table entry
  typedef struct packed {
    logic [7:0]  job;
    logic [15:0] remaining;
    logic [7:0]  priority_lvl;
  } slot_t;

  // Sequencer to scan unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

  // Scan unit status
  typedef struct packed {
    logic [SLOT_W-1:0] idx;
    logic              last;
    logic              found;
    logic [SLOT_W-1:0] best_idx;
    logic [7:0]        best_prio;
  } scan_stat_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_ARRIVE
  } state_e;

endpackage

FILE: hdl/pps_table.sv
module pps_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [pps_pkg::SLOT_W-1:0]  wr_idx_i,
  input  pps_pkg::slot_t              wr_data_i,
  input  logic                        clr_en_i,
  input  logic [pps_pkg::SLOT_W-1:0]  clr_idx_i,
  input  logic [pps_pkg::SLOT_W-1:0]  rd_idx_i,
  output pps_pkg::slot_t              rd_data_o,
  output logic [pps_pkg::SLOTS-1:0]   valid_o
);

  pps_pkg::slot_t             slot_q [pps_pkg::SLOTS];
  logic [pps_pkg::SLOTS-1:0]  valid_q;

  // Entry payload, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_q[wr_idx_i] <= wr_data_i;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (clr_en_i) begin
        valid_q[clr_idx_i] <= 1'b0;
      end
    end
  end

  assign rd_data_o = slot_q[rd_idx_i];
  assign valid_o   = valid_q;

endmodule

FILE: hdl/pps_scan.sv
module pps_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pps_pkg::scan_ctrl_t  ctrl_i,
  input  logic                 cur_valid_i,
  input  logic [7:0]           cur_prio_i,
  output pps_pkg::scan_stat_t  stat_o
);

  logic [pps_pkg::SLOT_W-1:0] idx_q, idx_d;
  logic [pps_pkg::SLOT_W-1:0] best_q, best_d;
  logic [7:0]                 prio_q, prio_d;
  logic                       found_q, found_d;
  logic                       better;

  // Shared comparator: strictly better keeps ties on the lower slot
  assign better = cur_valid_i && (!found_q || (cur_prio_i < prio_q));

  always_comb begin
    idx_d   = idx_q;
    best_d  = best_q;
    prio_d  = prio_q;
    found_d = found_q;
    if (ctrl_i.clear) begin
      idx_d   = '0;
      found_d = 1'b0;
    end else if (ctrl_i.step) begin
      idx_d = idx_q + 1'b1;
      if (better) begin
        best_d  = idx_q;
        prio_d  = cur_prio_i;
        found_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    prio_q <= prio_d;
  end

  assign stat_o.idx       = idx_q;
  assign stat_o.last      = (idx_q == pps_pkg::LAST_SLOT);
  assign stat_o.found     = found_q;
  assign stat_o.best_idx  = best_q;
  assign stat_o.best_prio = prio_q;

endmodule

FILE: hdl/preemptive_priority_scheduler_unit.sv
// Tick word: accept in ST_IDLE, scan every slot in ST_SCAN, then apply in ST_APPLY.
// Arrival word: accept, then ST_ARRIVE. One shared comparator scan sets the tick time.
// One word in flight; the result register frees the input side once it is loaded.
// Reset (async, active low) clears slot valid bits, running job state and the time count.
// Slot payload is not reset; no clearing pass is needed.
module preemptive_priority_scheduler_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pps_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pps_pkg::out_word_t out_word_o
);

  pps_pkg::state_e     state_q, state_d;
  pps_pkg::in_word_t   req_q;
  pps_pkg::out_word_t  out_q, out_d;
  logic                out_valid_q;
  logic                out_free;
  logic                in_fire;
  logic                out_load;

  logic                run_active_q, run_active_d;
  logic [7:0]          run_job_q, run_job_d;
  logic [15:0]         run_rem_q, run_rem_d;
  logic [7:0]          run_prio_q, run_prio_d;
  logic [31:0]         time_q;

  pps_pkg::scan_ctrl_t scan_ctrl;
  pps_pkg::scan_stat_t scan_stat;

  logic                        tbl_wr_en, tbl_clr_en;
  logic [pps_pkg::SLOT_W-1:0]  tbl_wr_idx, tbl_rd_idx;
  pps_pkg::slot_t              tbl_wr_data, tbl_rd_data;
  logic [pps_pkg::SLOTS-1:0]   valid;

  logic [pps_pkg::SLOT_W-1:0]  free_idx;
  logic                        tbl_full;
  logic                        arr_store;

  logic                        disp, preempt, cur_active;
  logic [7:0]                  cur_job, cur_prio;
  logic [15:0]                 cur_rem, rem_dec;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_fire  = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_word_i.req_type == pps_pkg::REQ_ARRIVE) ?
                    pps_pkg::ST_ARRIVE : pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_SCAN: begin
        if (scan_stat.last) begin
          state_d = pps_pkg::ST_APPLY;
        end
      end
      pps_pkg::ST_APPLY, pps_pkg::ST_ARRIVE: begin
        if (out_free) begin
          state_d = pps_pkg::ST_IDLE;
        end
      end
      default: state_d = pps_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o      = 1'b1;
    scan_ctrl.clear = 1'b0;
    scan_ctrl.step  = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        in_stall_o      = 1'b0;
        scan_ctrl.clear = 1'b1;
      end
      pps_pkg::ST_SCAN: begin
        scan_ctrl.step = 1'b1;
      end
      pps_pkg::ST_APPLY, pps_pkg::ST_ARRIVE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Held request word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_word_i;
    end
  end

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    for (int k = pps_pkg::SLOTS - 1; k >= 0; k--) begin
      if (!valid[k]) begin
        free_idx = pps_pkg::SLOT_W'(k);
      end
    end
  end
  assign tbl_full  = &valid;
  assign arr_store = (req_q.job_burst != 16'd0) && !tbl_full;

  // Tick apply: dispatch or preempt against the scanned best slot
  assign disp       = scan_stat.found && !run_active_q;
  assign preempt    = scan_stat.found && run_active_q && (scan_stat.best_prio < run_prio_q);
  assign cur_active = run_active_q || disp;
  assign cur_job    = (disp || preempt) ? tbl_rd_data.job          : run_job_q;
  assign cur_rem    = (disp || preempt) ? tbl_rd_data.remaining    : run_rem_q;
  assign cur_prio   = (disp || preempt) ? tbl_rd_data.priority_lvl : run_prio_q;
  assign rem_dec    = cur_rem - 16'd1;

  // Table port selection
  always_comb begin
    tbl_rd_idx  = (state_q == pps_pkg::ST_APPLY) ? scan_stat.best_idx : scan_stat.idx;
    tbl_wr_en   = 1'b0;
    tbl_wr_idx  = free_idx;
    tbl_wr_data = '{job: req_q.job_id, remaining: req_q.job_burst,
                    priority_lvl: req_q.job_priority};
    tbl_clr_en  = 1'b0;
    if (out_load && (state_q == pps_pkg::ST_ARRIVE)) begin
      tbl_wr_en = arr_store;
    end else if (out_load && (state_q == pps_pkg::ST_APPLY)) begin
      tbl_wr_idx  = scan_stat.best_idx;
      tbl_wr_data = '{job: run_job_q, remaining: run_rem_q, priority_lvl: run_prio_q};
      tbl_wr_en   = preempt;
      tbl_clr_en  = disp;
    end
  end

  // Run state and result word
  always_comb begin
    run_active_d = run_active_q;
    run_job_d    = run_job_q;
    run_rem_d    = run_rem_q;
    run_prio_d   = run_prio_q;
    out_d        = out_q;
    if (out_load && (state_q == pps_pkg::ST_APPLY)) begin
      if (cur_active) begin
        run_job_d  = cur_job;
        run_rem_d  = rem_dec;
        run_prio_d = cur_prio;
      end
      run_active_d     = cur_active && (rem_dec != 16'd0);
      out_d.running_id = cur_active ? cur_job : 8'd0;
      out_d.idle       = !cur_active;
      out_d.dispatched = disp || preempt;
      out_d.table_full = 1'b0;
      out_d.now_time   = time_q + 32'd1;
    end else if (out_load && (state_q == pps_pkg::ST_ARRIVE)) begin
      out_d.running_id = run_active_q ? run_job_q : 8'd0;
      out_d.idle       = !run_active_q;
      out_d.dispatched = 1'b0;
      out_d.table_full = (req_q.job_burst != 16'd0) && tbl_full;
      out_d.now_time   = time_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q <= 1'b0;
      run_job_q    <= '0;
      run_rem_q    <= '0;
      run_prio_q   <= '0;
      time_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      run_active_q <= run_active_d;
      run_job_q    <= run_job_d;
      run_rem_q    <= run_rem_d;
      run_prio_q   <= run_prio_d;
      if (out_load && (state_q == pps_pkg::ST_APPLY)) begin
        time_q <= time_q + 32'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  pps_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tbl_wr_en),
    .wr_idx_i  (tbl_wr_idx),
    .wr_data_i (tbl_wr_data),
    .clr_en_i  (tbl_clr_en),
    .clr_idx_i (scan_stat.best_idx),
    .rd_idx_i  (tbl_rd_idx),
    .rd_data_o (tbl_rd_data),
    .valid_o   (valid)
  );

  pps_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .cur_valid_i (valid[scan_stat.idx]),
    .cur_prio_i  (tbl_rd_data.priority_lvl),
    .stat_o      (scan_stat)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int N_RANDOM    = 1430;
  localparam int QUIET_TAIL  = 200;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 3 * (pps_pkg::SLOTS + 2);
  localparam int CYCLE_LIMIT = 400000;

  // Scheduler predictor plus the queue of status words still due
  class sched_checker;
    bit                 slot_used[pps_pkg::SLOTS];
    pps_pkg::slot_t     slots[pps_pkg::SLOTS];
    bit                 cpu_busy;
    pps_pkg::slot_t     cpu;
    logic [31:0]        clock_now;
    pps_pkg::out_word_t status_due[$];
    int                 arrivals, ticks, dispatches, preempts, completions, drops;
    int                 checked, mismatches;

    function new();
      int k;
      for (k = 0; k < pps_pkg::SLOTS; k++) slot_used[k] = 1'b0;
      cpu_busy  = 1'b0;
      cpu       = '0;
      clock_now = '0;
    endfunction

    function bit table_full_now();
      int k;
      for (k = 0; k < pps_pkg::SLOTS; k++) if (!slot_used[k]) return 1'b0;
      return 1'b1;
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    // Apply one accepted request to the predicted state, queue its status word
    function void log_request(pps_pkg::in_word_t w);
      pps_pkg::out_word_t st;
      pps_pkg::slot_t     held;
      int                 k, best, free_k;
      st = '0;
      if (w.req_type == pps_pkg::REQ_ARRIVE) begin
        arrivals++;
        if (w.job_burst != '0) begin
          free_k = -1;
          for (k = pps_pkg::SLOTS - 1; k >= 0; k--) if (!slot_used[k]) free_k = k;
          if (free_k < 0) begin
            st.table_full = 1'b1;
            drops++;
          end else begin
            slot_used[free_k]          = 1'b1;
            slots[free_k].job          = w.job_id;
            slots[free_k].remaining    = w.job_burst;
            slots[free_k].priority_lvl = w.job_priority;
          end
        end
        st.running_id = cpu_busy ? cpu.job : 8'd0;
        st.idle       = !cpu_busy;
      end else begin
        ticks++;
        // best ready job, ties to the lowest slot
        best = -1;
        for (k = 0; k < pps_pkg::SLOTS; k++) begin
          if (slot_used[k] &&
              (best < 0 || slots[k].priority_lvl < slots[best].priority_lvl))
            best = k;
        end
        if (best >= 0) begin
          if (!cpu_busy) begin
            cpu_busy        = 1'b1;
            cpu             = slots[best];
            slot_used[best] = 1'b0;
            st.dispatched   = 1'b1;
            dispatches++;
          end else if (slots[best].priority_lvl < cpu.priority_lvl) begin
            // strictly better job swaps in; the old one keeps its remaining time
            held          = cpu;
            cpu           = slots[best];
            slots[best]   = held;
            st.dispatched = 1'b1;
            dispatches++;
            preempts++;
          end
        end
        if (cpu_busy) begin
          st.running_id = cpu.job;
          cpu.remaining = cpu.remaining - 16'd1;
          if (cpu.remaining == '0) begin
            cpu_busy = 1'b0;
            completions++;
          end
        end else begin
          st.idle = 1'b1;
        end
        clock_now = clock_now + 32'd1;
      end
      st.now_time = clock_now;
      status_due.push_back(st);
    endfunction

    function void check_status(pps_pkg::out_word_t got);
      pps_pkg::out_word_t want;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: word with nothing pending: id=%0d idle=%0b disp=%0b full=%0b t=%0d",
                   got.running_id, got.idle, got.dispatched, got.table_full, got.now_time);
        return;
      end
      want = status_due.pop_front();
      checked++;
      if (got.running_id !== want.running_id || got.idle !== want.idle ||
          got.dispatched !== want.dispatched || got.table_full !== want.table_full ||
          got.now_time !== want.now_time) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: word %0d expected id=%0d idle=%0b disp=%0b full=%0b t=%0d",
                   checked, want.running_id, want.idle, want.dispatched, want.table_full,
                   want.now_time);
          $display("ERROR: word %0d actual   id=%0d idle=%0b disp=%0b full=%0b t=%0d",
                   checked, got.running_id, got.idle, got.dispatched, got.table_full,
                   got.now_time);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  pps_pkg::in_word_t  in_word = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  pps_pkg::out_word_t out_word;

  sched_checker sched;
  bit           tx_gaps_en = 1'b1;
  bit           rx_stall_en = 1'b1;
  bit           long_hold_req = 1'b0;
  int           cycle_cnt = 0;

  preemptive_priority_scheduler_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Watchdog
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("ERROR: timeout after %0d cycles", cycle_cnt);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sched.check_status(out_word);
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : rx_side
    int n;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic pps_pkg::in_word_t arrival(logic [7:0] id, logic [15:0] burst,
                                                logic [7:0] prio);
    pps_pkg::in_word_t w;
    w.req_type     = pps_pkg::REQ_ARRIVE;
    w.job_id       = id;
    w.job_burst    = burst;
    w.job_priority = prio;
    return w;
  endfunction

  // Tick with junk in the job fields
  function automatic pps_pkg::in_word_t tick_word();
    pps_pkg::in_word_t w;
    w.req_type     = pps_pkg::REQ_TICK;
    w.job_id       = 8'($urandom_range(0, 255));
    w.job_burst    = 16'($urandom_range(0, 65535));
    w.job_priority = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // Offer one word, optionally after a gap; return at the edge that takes it
  task automatic send_word(input pps_pkg::in_word_t w);
    int gap;
    if (tx_gaps_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sched.log_request(w);
  endtask

  initial begin
    int          n, k, arrive_pct, prio_top;
    logic [15:0] burst;
    logic [7:0]  prio;
    sched = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, one-unit job, equal and better priority, zero burst,
    // duplicate id, fill the table and drop
    send_word(tick_word());
    send_word(arrival(8'h00, 16'h0001, 8'hFF));
    send_word(tick_word());
    send_word(tick_word());
    send_word(arrival(8'hFF, 16'hFFFF, 8'hFF));
    send_word(tick_word());
    send_word(arrival(8'h55, 16'h0002, 8'hFF));
    send_word(tick_word());
    send_word(arrival(8'hAA, 16'h0003, 8'h00));
    send_word(tick_word());
    send_word(arrival(8'h07, 16'h0000, 8'h00));
    send_word(arrival(8'hAA, 16'h0001, 8'h00));
    send_word(tick_word());
    for (k = 0; k < 7; k++) send_word(arrival(8'(8'h10 + k), 16'(k + 1), 8'(8'h80 - k)));
    send_word(arrival(8'hC3, 16'h8000, 8'h01));
    send_word(tick_word());
    send_word(tick_word());

    // random: load level and priority spread change every 50 words
    arrive_pct = 30;
    prio_top   = 254;
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       arrive_pct = 15;
          1:       arrive_pct = 30;
          default: arrive_pct = 60;
        endcase
        case ($urandom_range(0, 2))
          0:       prio_top = 3;
          1:       prio_top = 15;
          default: prio_top = 254;
        endcase
      end
      if (n == 400) long_hold_req = 1'b1;
      if (n == N_RANDOM - QUIET_TAIL) begin
        tx_gaps_en  = 1'b0;
        rx_stall_en = 1'b0;
      end
      if ($urandom_range(0, 99) < arrive_pct) begin
        // full table: any burst, it gets dropped
        if (sched.table_full_now()) burst = 16'($urandom_range(0, 65535));
        else if ($urandom_range(0, 99) < 2) burst = '0;
        else if ($urandom_range(0, 9) == 0) burst = 16'($urandom_range(13, 60));
        else burst = 16'($urandom_range(1, 12));
        prio = ($urandom_range(0, 19) == 0) ? 8'hFF : 8'($urandom_range(0, prio_top));
        send_word(arrival(8'($urandom_range(0, 255)), burst, prio));
      end else begin
        send_word(tick_word());
      end
    end
    in_valid <= 1'b0;

    // drain
    while (sched.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run: %0d arrivals, %0d ticks; %0d dispatches (%0d preemptions), %0d jobs done",
             sched.arrivals, sched.ticks, sched.dispatches, sched.preempts, sched.completions);
    $display("Run: %0d arrivals dropped on a full table, %0d words checked, %0d mismatches",
             sched.drops, sched.checked, sched.mismatches);
    if (sched.mismatches == 0 && sched.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
